### rtl/csa_pkg.sv
// ----------------------------------------------------------------------------
// csa_pkg
// Shared widths, command and status codes and the cell control group of the
// contiguous segment allocator.
// ----------------------------------------------------------------------------
package csa_pkg;

	localparam int DEF_MAX_SEGMENTS = 64;
	localparam int DEF_ADDR_BITS    = 20;
	localparam int DEF_OWNER_BITS   = 8;

	localparam int KIND_W     = 2;
	localparam int OWNER_ID_W = 8;
	localparam int SIZE_W     = 21;
	localparam int FIT_W      = 2;
	localparam int STATUS_W   = 3;
	localparam int OUT_ADDR_W = 20;
	localparam int CFG_W      = 21;

	localparam int RST_MEM_SIZE = 1048576;

	localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COMPACT = 2'd2;

	localparam logic [FIT_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
	localparam logic [FIT_W-1:0] FIT_WORST = 2'd2;
	localparam logic [FIT_W-1:0] FIT_BAD   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_HOLE       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NONE_RELEASED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_SIZE      = 3'd4;
	localparam logic [STATUS_W-1:0] ST_BAD_STRATEGY  = 3'd5;

	typedef struct packed {
		logic shift;
		logic init;
	} cell_ctrl_t;

endpackage

### rtl/csa_cell.sv
// ----------------------------------------------------------------------------
// csa_cell
// One slot of the segment ring: holds one entry and loads its neighbor's
// entry whenever the ring rotates.
// ----------------------------------------------------------------------------
module csa_cell #(
	parameter int ADDR_BITS  = csa_pkg::DEF_ADDR_BITS,
	parameter int OWNER_BITS = csa_pkg::DEF_OWNER_BITS,
	parameter bit FIRST      = 1'b0,
	parameter logic [ADDR_BITS-1:0] RST_END = '0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  csa_pkg::cell_ctrl_t   ctrl,
	input  logic [ADDR_BITS-1:0]  init_end,
	input  logic [ADDR_BITS-1:0]  d_start,
	input  logic [ADDR_BITS-1:0]  d_end,
	input  logic                  d_used,
	input  logic [OWNER_BITS-1:0] d_owner,
	input  logic                  d_valid,
	input  logic                  d_head,
	output logic [ADDR_BITS-1:0]  q_start,
	output logic [ADDR_BITS-1:0]  q_end,
	output logic                  q_used,
	output logic [OWNER_BITS-1:0] q_owner,
	output logic                  q_valid,
	output logic                  q_head
);
	import csa_pkg::*;

	logic [ADDR_BITS-1:0]  start_q;
	logic [ADDR_BITS-1:0]  end_q;
	logic                  used_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic                  valid_q;
	logic                  head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= FIRST ? RST_END : '0;
			used_q  <= 1'b0;
			valid_q <= FIRST;
			head_q  <= FIRST;
		end else if (ctrl.init) begin
			// only the first slot survives a re-init, as one free segment
			start_q <= '0;
			end_q   <= FIRST ? init_end : '0;
			used_q  <= 1'b0;
			valid_q <= FIRST;
			head_q  <= FIRST;
		end else if (ctrl.shift) begin
			start_q <= d_start;
			end_q   <= d_end;
			used_q  <= d_used;
			valid_q <= d_valid;
			head_q  <= d_head;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift && !ctrl.init) begin
			owner_q <= d_owner;
		end
	end

	assign q_start = start_q;
	assign q_end   = end_q;
	assign q_used  = used_q;
	assign q_owner = owner_q;
	assign q_valid = valid_q;
	assign q_head  = head_q;

endmodule

### rtl/csa_ctrl.sv
// ----------------------------------------------------------------------------
// csa_ctrl
// Command sequencer: reads the entry leaving the ring head, rewrites it and
// feeds the ring tail, with one hold register for splits and merges.
// ----------------------------------------------------------------------------
module csa_ctrl #(
	parameter int MAX_SEGMENTS = csa_pkg::DEF_MAX_SEGMENTS,
	parameter int ADDR_BITS    = csa_pkg::DEF_ADDR_BITS,
	parameter int OWNER_BITS   = csa_pkg::DEF_OWNER_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [csa_pkg::CFG_W-1:0]      cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [csa_pkg::KIND_W-1:0]     kind,
	input  logic [csa_pkg::OWNER_ID_W-1:0] owner_id,
	input  logic [csa_pkg::SIZE_W-1:0]     request_size,
	input  logic [csa_pkg::FIT_W-1:0]      fit_strategy,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [csa_pkg::STATUS_W-1:0]   status,
	output logic [csa_pkg::OUT_ADDR_W-1:0] start_address,
	input  logic [ADDR_BITS-1:0]           hd_start,
	input  logic [ADDR_BITS-1:0]           hd_end,
	input  logic                           hd_used,
	input  logic [OWNER_BITS-1:0]          hd_owner,
	input  logic                           hd_valid,
	input  logic                           hd_head,
	output logic [ADDR_BITS-1:0]           tl_start,
	output logic [ADDR_BITS-1:0]           tl_end,
	output logic                           tl_used,
	output logic [OWNER_BITS-1:0]          tl_owner,
	output logic                           tl_valid,
	output logic                           tl_head,
	output csa_pkg::cell_ctrl_t            cctl,
	output logic [ADDR_BITS-1:0]           init_end
);
	import csa_pkg::*;

	localparam int N     = MAX_SEGMENTS;
	localparam int LW    = ADDR_BITS + 1;
	localparam int CW    = (LW > SIZE_W) ? LW : SIZE_W;
	localparam int CNTW  = $clog2(N);
	localparam int CNT1W = $clog2(N + 1);
	localparam logic [CW-1:0] SPAN = CW'(1) << ADDR_BITS;
	localparam logic [LW-1:0] RST_MEM =
		(ADDR_BITS >= 20) ? LW'(RST_MEM_SIZE) : LW'(SPAN);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ALIGN = 6'b000010,
		S_SCAN  = 6'b000100,
		S_RUN   = 6'b001000,
		S_FLUSH = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	function automatic logic [LW-1:0] clamp_size(input logic [CFG_W-1:0] v);
		logic [CW-1:0] w;
		w = CW'(v);
		if (w == '0) return LW'(1);
		if (w > SPAN) return LW'(SPAN);
		return LW'(w);
	endfunction

	state_t                state_q, state_d;
	logic [KIND_W-1:0]     op_q, op_d;
	logic [OWNER_BITS-1:0] own_q, own_d;
	logic [SIZE_W-1:0]     size_q, size_d;
	logic [FIT_W-1:0]      fit_q, fit_d;
	logic [CNTW-1:0]       cnt_q, cnt_d;
	logic [CNTW-1:0]       pick_q, pick_d;
	logic [LW-1:0]         pick_len_q, pick_len_d;
	logic                  found_q, found_d;
	logic [CNT1W-1:0]      count_q, count_d;
	logic [LW-1:0]         mem_q, mem_d;
	logic [ADDR_BITS-1:0]  h_start_q, h_start_d;
	logic [ADDR_BITS-1:0]  h_end_q, h_end_d;
	logic                  h_used_q, h_used_d;
	logic [OWNER_BITS-1:0] h_owner_q, h_owner_d;
	logic                  h_head_q, h_head_d;
	logic                  hv_q, hv_d;
	logic                  rel_q, rel_d;
	logic [LW-1:0]         next_q, next_d;
	logic [CNT1W-1:0]      w_q, w_d;
	logic                  first_q, first_d;
	logic [STATUS_W-1:0]   st_q, st_d;
	logic [ADDR_BITS-1:0]  addr_q, addr_d;
	logic                  ov_q, ov_d;
	logic [STATUS_W-1:0]   ostat_q, ostat_d;
	logic [OUT_ADDR_W-1:0] oaddr_q, oaddr_d;

	logic [LW-1:0]        e_len;
	logic                 fits;
	logic                 take;
	logic                 rel_hit;
	logic                 e_used_r;
	logic                 split;
	logic [ADDR_BITS-1:0] split_end;
	logic                 shift;

	assign e_len     = LW'(hd_end) - LW'(hd_start) + LW'(1);
	assign fits      = hd_valid && !hd_used && (CW'(size_q) <= CW'(e_len));
	assign rel_hit   = hd_valid && hd_used && (hd_owner == own_q);
	assign e_used_r  = hd_used && !rel_hit;
	assign split     = CW'(pick_len_q) != CW'(size_q);
	assign split_end = ADDR_BITS'(CW'(hd_start) + CW'(size_q) - CW'(1));
	assign init_end  = ADDR_BITS'(clamp_size(cfg_wr_data) - LW'(1));

	always_comb begin
		take = 1'b0;
		case (fit_q)
			FIT_FIRST: take = fits && !found_q;
			FIT_BEST:  take = fits && (!found_q || e_len < pick_len_q);
			FIT_WORST: take = fits && (!found_q || e_len > pick_len_q);
			default:   take = 1'b0;
		endcase
	end

	always_comb begin
		state_d    = state_q;
		op_d       = op_q;
		own_d      = own_q;
		size_d     = size_q;
		fit_d      = fit_q;
		cnt_d      = cnt_q;
		pick_d     = pick_q;
		pick_len_d = pick_len_q;
		found_d    = found_q;
		count_d    = count_q;
		mem_d      = mem_q;
		h_start_d  = h_start_q;
		h_end_d    = h_end_q;
		h_used_d   = h_used_q;
		h_owner_d  = h_owner_q;
		h_head_d   = h_head_q;
		hv_d       = hv_q;
		rel_d      = rel_q;
		next_d     = next_q;
		w_d        = w_q;
		first_d    = first_q;
		st_d       = st_q;
		addr_d     = addr_q;
		ov_d       = ov_q && !out_ready;
		ostat_d    = ostat_q;
		oaddr_d    = oaddr_q;
		shift      = 1'b0;
		tl_start   = hd_start;
		tl_end     = hd_end;
		tl_used    = hd_used;
		tl_owner   = hd_owner;
		tl_valid   = 1'b0;
		tl_head    = hd_head;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d    = kind;
					own_d   = OWNER_BITS'(owner_id);
					size_d  = request_size;
					fit_d   = fit_strategy;
					cnt_d   = '0;
					found_d = 1'b0;
					hv_d    = 1'b0;
					rel_d   = 1'b0;
					next_d  = '0;
					w_d     = '0;
					first_d = 1'b0;
					addr_d  = '0;
					st_d    = ST_OK;
					unique case (kind) inside
						KIND_REQUEST: begin
							if (fit_strategy == FIT_BAD) begin
								st_d    = ST_BAD_STRATEGY;
								state_d = S_DONE;
							end else if (request_size == '0) begin
								st_d    = ST_BAD_SIZE;
								state_d = S_DONE;
							end else begin
								state_d = S_ALIGN;
							end
						end
						KIND_RELEASE, KIND_COMPACT: state_d = S_ALIGN;
						default: begin
							st_d    = ST_BAD_STRATEGY;
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_ALIGN: begin
				// rotate until the first logical entry sits at the head
				if (hd_valid && hd_head) begin
					cnt_d   = '0;
					state_d = (op_q == KIND_REQUEST) ? S_SCAN : S_RUN;
				end else begin
					shift    = 1'b1;
					tl_valid = hd_valid;
				end
			end
			S_SCAN: begin
				shift    = 1'b1;
				tl_valid = hd_valid;
				if (take) begin
					found_d    = 1'b1;
					pick_d     = cnt_q;
					pick_len_d = e_len;
				end
				if (cnt_q == CNTW'(N - 1)) begin
					cnt_d = '0;
					if (!found_d) begin
						st_d    = ST_NO_HOLE;
						state_d = S_DONE;
					end else if (CW'(pick_len_d) != CW'(size_q) &&
					             count_q == CNT1W'(N)) begin
						st_d    = ST_TABLE_FULL;
						state_d = S_DONE;
					end else begin
						state_d = S_RUN;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_RUN: begin
				shift = 1'b1;
				case (op_q)
					KIND_REQUEST: begin
						if (cnt_q == pick_q) begin
							tl_valid = 1'b1;
							tl_used  = 1'b1;
							tl_owner = own_q;
							addr_d   = hd_start;
							if (split) begin
								// remainder waits in the hold register
								tl_end    = split_end;
								h_start_d = split_end + 1'b1;
								h_end_d   = hd_end;
								h_used_d  = 1'b0;
								h_owner_d = own_q;
								h_head_d  = 1'b0;
								hv_d      = 1'b1;
								count_d   = count_q + 1'b1;
							end
						end else if (hv_q) begin
							tl_start = h_start_q;
							tl_end   = h_end_q;
							tl_used  = h_used_q;
							tl_owner = h_owner_q;
							tl_head  = h_head_q;
							tl_valid = 1'b1;
							if (hd_valid) begin
								h_start_d = hd_start;
								h_end_d   = hd_end;
								h_used_d  = hd_used;
								h_owner_d = hd_owner;
								h_head_d  = hd_head;
							end else begin
								hv_d = 1'b0;
							end
						end else begin
							tl_valid = hd_valid;
						end
					end
					KIND_RELEASE: begin
						if (rel_hit) rel_d = 1'b1;
						if (!hd_valid) begin
							tl_valid = 1'b0;
						end else if (hv_q && !h_used_q && !e_used_r) begin
							// free neighbor joins the held free segment
							h_end_d  = hd_end;
							count_d  = count_q - 1'b1;
							tl_valid = 1'b0;
						end else begin
							tl_start  = h_start_q;
							tl_end    = h_end_q;
							tl_used   = h_used_q;
							tl_owner  = h_owner_q;
							tl_head   = h_head_q;
							tl_valid  = hv_q;
							h_start_d = hd_start;
							h_end_d   = hd_end;
							h_used_d  = e_used_r;
							h_owner_d = hd_owner;
							h_head_d  = hd_head;
							hv_d      = 1'b1;
						end
					end
					KIND_COMPACT: begin
						if (hd_valid && hd_used) begin
							tl_valid = 1'b1;
							tl_start = ADDR_BITS'(next_q);
							tl_end   = ADDR_BITS'(next_q + e_len - LW'(1));
							tl_used  = 1'b1;
							tl_owner = hd_owner;
							tl_head  = !first_q;
							first_d  = 1'b1;
							next_d   = next_q + e_len;
							w_d      = w_q + 1'b1;
						end else begin
							tl_valid = 1'b0;
						end
					end
					default: tl_valid = hd_valid;
				endcase
				if (cnt_q == CNTW'(N - 1)) begin
					cnt_d = '0;
					if (op_q == KIND_COMPACT) begin
						if (next_d < mem_q && w_d < CNT1W'(N)) begin
							h_start_d = ADDR_BITS'(next_d);
							h_end_d   = ADDR_BITS'(mem_q - LW'(1));
							h_used_d  = 1'b0;
							h_head_d  = !first_d;
							hv_d      = 1'b1;
							count_d   = w_d + 1'b1;
						end else begin
							count_d = w_d;
						end
					end
					if (op_q == KIND_RELEASE) begin
						st_d = rel_d ? ST_OK : ST_NONE_RELEASED;
					end
					state_d = hv_d ? S_FLUSH : S_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_FLUSH: begin
				// the held entry travels forward until it lands in an empty (invalid) slot
				shift    = 1'b1;
				tl_start = h_start_q;
				tl_end   = h_end_q;
				tl_used  = h_used_q;
				tl_owner = h_owner_q;
				tl_head  = h_head_q;
				tl_valid = 1'b1;
				if (hd_valid) begin
					h_start_d = hd_start;
					h_end_d   = hd_end;
					h_used_d  = hd_used;
					h_owner_d = hd_owner;
					h_head_d  = hd_head;
				end else begin
					hv_d    = 1'b0;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!ov_q || out_ready) begin
					ov_d    = 1'b1;
					ostat_d = st_q;
					oaddr_d = OUT_ADDR_W'(addr_q);
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (cfg_wr_en) begin
			mem_d   = clamp_size(cfg_wr_data);
			count_d = CNT1W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= CNT1W'(1);
			mem_q   <= RST_MEM;
			hv_q    <= 1'b0;
			ov_q    <= 1'b0;
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			mem_q   <= mem_d;
			hv_q    <= hv_d;
			ov_q    <= ov_d;
			cnt_q   <= cnt_d;
			found_q <= found_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q       <= op_d;
		own_q      <= own_d;
		size_q     <= size_d;
		fit_q      <= fit_d;
		pick_q     <= pick_d;
		pick_len_q <= pick_len_d;
		h_start_q  <= h_start_d;
		h_end_q    <= h_end_d;
		h_used_q   <= h_used_d;
		h_owner_q  <= h_owner_d;
		h_head_q   <= h_head_d;
		rel_q      <= rel_d;
		next_q     <= next_d;
		w_q        <= w_d;
		first_q    <= first_d;
		st_q       <= st_d;
		addr_q     <= addr_d;
		ostat_q    <= ostat_d;
		oaddr_q    <= oaddr_d;
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = ov_q;
	assign status        = ostat_q;
	assign start_address = oaddr_q;
	assign cctl.shift    = shift && !cfg_wr_en;
	assign cctl.init     = cfg_wr_en;

`ifndef SYNTHESIS
	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !hv_q)
		else $error("hold register still full in idle");
	a_flush_has_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) |-> hv_q)
		else $error("flush without a held entry");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= CNT1W'(N)))
		else $error("segment count out of range");
	a_run_has_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && op_q == KIND_REQUEST) |-> found_q)
		else $error("request rewrite without a chosen hole");
`endif

endmodule

### rtl/contiguous_segment_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_segment_allocator
// Sequence: a request aligns the ring, scans it, rewrites it, drains the hold
//   register and posts; release and compact align, rewrite, drain and post.
//   Rejected commands skip the ring and post their result directly.
// One command at a time; the next one is taken once the result is posted, and
//   the ring rotates one entry per cycle unless a memory_size write holds it.
// Reset (arst_n, async): one free segment over 2^20 units (or 2^ADDR_BITS if
//   ADDR_BITS < 20), no clearing pass; a memory_size write re-inits the ring.
// ----------------------------------------------------------------------------
module contiguous_segment_allocator #(
	parameter int MAX_SEGMENTS = csa_pkg::DEF_MAX_SEGMENTS,
	parameter int ADDR_BITS    = csa_pkg::DEF_ADDR_BITS,
	parameter int OWNER_BITS   = csa_pkg::DEF_OWNER_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [csa_pkg::CFG_W-1:0]      cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [csa_pkg::KIND_W-1:0]     kind,
	input  logic [csa_pkg::OWNER_ID_W-1:0] owner_id,
	input  logic [csa_pkg::SIZE_W-1:0]     request_size,
	input  logic [csa_pkg::FIT_W-1:0]      fit_strategy,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [csa_pkg::STATUS_W-1:0]   status,
	output logic [csa_pkg::OUT_ADDR_W-1:0] start_address
);
	import csa_pkg::*;

	localparam int N  = MAX_SEGMENTS;
	localparam int LW = ADDR_BITS + 1;
	localparam logic [LW-1:0] SPAN_L = LW'(1) << ADDR_BITS;
	localparam logic [ADDR_BITS-1:0] RST_END =
		(ADDR_BITS >= 20) ? ADDR_BITS'(RST_MEM_SIZE - 1) : ADDR_BITS'(SPAN_L - LW'(1));

	logic [ADDR_BITS-1:0]  c_start [N+1];
	logic [ADDR_BITS-1:0]  c_end   [N+1];
	logic                  c_used  [N+1];
	logic [OWNER_BITS-1:0] c_owner [N+1];
	logic                  c_valid [N+1];
	logic                  c_head  [N+1];
	cell_ctrl_t            cctl;
	logic [ADDR_BITS-1:0]  init_end;

	// slot N is the tail input driven by the sequencer
	csa_ctrl #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.ADDR_BITS    (ADDR_BITS),
		.OWNER_BITS   (OWNER_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.owner_id      (owner_id),
		.request_size  (request_size),
		.fit_strategy  (fit_strategy),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.start_address (start_address),
		.hd_start      (c_start[0]),
		.hd_end        (c_end[0]),
		.hd_used       (c_used[0]),
		.hd_owner      (c_owner[0]),
		.hd_valid      (c_valid[0]),
		.hd_head       (c_head[0]),
		.tl_start      (c_start[N]),
		.tl_end        (c_end[N]),
		.tl_used       (c_used[N]),
		.tl_owner      (c_owner[N]),
		.tl_valid      (c_valid[N]),
		.tl_head       (c_head[N]),
		.cctl          (cctl),
		.init_end      (init_end)
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		csa_cell #(
			.ADDR_BITS  (ADDR_BITS),
			.OWNER_BITS (OWNER_BITS),
			.FIRST      (i == 0),
			.RST_END    (RST_END)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cctl),
			.init_end (init_end),
			.d_start  (c_start[i+1]),
			.d_end    (c_end[i+1]),
			.d_used   (c_used[i+1]),
			.d_owner  (c_owner[i+1]),
			.d_valid  (c_valid[i+1]),
			.d_head   (c_head[i+1]),
			.q_start  (c_start[i]),
			.q_end    (c_end[i]),
			.q_used   (c_used[i]),
			.q_owner  (c_owner[i]),
			.q_valid  (c_valid[i]),
			.q_head   (c_head[i])
		);
	end

endmodule
